[rtl/asi_pkg.sv]
// shared types, constants and helpers for the adaptive sorted intersection block
`default_nettype none

package asi_pkg;

    localparam int MAX_LEN     = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(MAX_LEN);
    localparam int CNT_W       = $clog2(MAX_LEN + 1);
    localparam int BL_W        = $clog2(CNT_W + 1);
    localparam int PROD_W      = CNT_W + BL_W;
    localparam int COST_W      = 9;

    localparam logic [1:0] OP_APPEND_A = 2'd0;
    localparam logic [1:0] OP_APPEND_B = 2'd1;
    localparam logic [1:0] OP_RUN      = 2'd2;

    localparam logic [1:0] METH_A_IN_B = 2'd0;
    localparam logic [1:0] METH_B_IN_A = 2'd1;
    localparam logic [1:0] METH_MERGE  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [5:0]        match_index;
        logic              match_valid;
        logic [COST_W-1:0] cost;
        logic [1:0]        method;
        logic              overflowed;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0] na;
        logic [CNT_W-1:0] nb;
        logic             ovf;
    } lst_status_t;

    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
    } rd_addr_t;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } cmp_res_t;

    // bit length of n, zero for zero
    function automatic logic [BL_W-1:0] bit_len(input logic [CNT_W-1:0] n);
        logic [BL_W-1:0] r;
        r = '0;
        for (int k = 0; k < CNT_W; k++)
        begin
            if (n[k])
            begin
                r = BL_W'(k + 1);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/asi_lists.sv]
// list storage: two value memories, fill counts and the dropped-append flag
`default_nettype none

module asi_lists (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire asi_pkg::cmd_t                    cmd,
    input  wire asi_pkg::rd_addr_t                rd,
    output logic [asi_pkg::VALUE_WIDTH-1:0]       a_rdata,
    output logic [asi_pkg::VALUE_WIDTH-1:0]       b_rdata,
    output asi_pkg::lst_status_t                  status
);

    logic [asi_pkg::VALUE_WIDTH-1:0] mem_a [asi_pkg::MAX_LEN];
    logic [asi_pkg::VALUE_WIDTH-1:0] mem_b [asi_pkg::MAX_LEN];
    logic [asi_pkg::VALUE_WIDTH-1:0] a_rdata_reg;
    logic [asi_pkg::VALUE_WIDTH-1:0] b_rdata_reg;
    logic [asi_pkg::CNT_W-1:0]       count_a_reg;
    logic [asi_pkg::CNT_W-1:0]       count_b_reg;
    logic                            ovf_reg;
    logic                            a_full;
    logic                            b_full;
    logic                            wr_a;
    logic                            wr_b;
    logic [asi_pkg::VALUE_WIDTH-1:0] wr_value;

    assign a_full   = count_a_reg == asi_pkg::CNT_W'(asi_pkg::MAX_LEN);
    assign b_full   = count_b_reg == asi_pkg::CNT_W'(asi_pkg::MAX_LEN);
    assign wr_a     = wr_en && cmd.operation == asi_pkg::OP_APPEND_A && !a_full;
    assign wr_b     = wr_en && cmd.operation == asi_pkg::OP_APPEND_B && !b_full;
    assign wr_value = cmd.value[asi_pkg::VALUE_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[count_a_reg[asi_pkg::IDX_W-1:0]] <= wr_value;
        end
        if (wr_b)
        begin
            mem_b[count_b_reg[asi_pkg::IDX_W-1:0]] <= wr_value;
        end
        a_rdata_reg <= mem_a[rd.a];
        b_rdata_reg <= mem_b[rd.b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg <= '0;
            count_b_reg <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            case (cmd.operation)
                asi_pkg::OP_APPEND_A:
                begin
                    if (a_full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        count_a_reg <= count_a_reg + 1'b1;
                    end
                end
                asi_pkg::OP_APPEND_B:
                begin
                    if (b_full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        count_b_reg <= count_b_reg + 1'b1;
                    end
                end
                // the sequencer latches the counts on this same edge
                asi_pkg::OP_RUN:
                begin
                    count_a_reg <= '0;
                    count_b_reg <= '0;
                    ovf_reg     <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign a_rdata    = a_rdata_reg;
    assign b_rdata    = b_rdata_reg;
    assign status.na  = count_a_reg;
    assign status.nb  = count_b_reg;
    assign status.ovf = ovf_reg;

endmodule

`default_nettype wire

[rtl/asi_cmp.sv]
// shared magnitude comparator between the two list read ports
`default_nettype none

module asi_cmp (
    input  wire logic [asi_pkg::VALUE_WIDTH-1:0] a,
    input  wire logic [asi_pkg::VALUE_WIDTH-1:0] b,
    output asi_pkg::cmp_res_t                    res
);

    assign res.lt = a < b;
    assign res.eq = a == b;
    assign res.gt = b < a;

endmodule

`default_nettype wire

[rtl/asi_seq.sv]
// run sequencer: cost choice, binary search and merge steps, result emission
`default_nettype none

module asi_seq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire asi_pkg::lst_status_t status,
    input  wire asi_pkg::cmp_res_t    cmp,
    input  wire logic                 out_free,
    output asi_pkg::rd_addr_t         rd,
    output logic                      busy,
    output logic                      emit,
    output asi_pkg::res_t             emit_item
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_COST   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_MERGE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam int CW = asi_pkg::CNT_W;
    localparam int IW = asi_pkg::IDX_W;
    localparam int PW = asi_pkg::PROD_W;

    logic [2:0]                  state_reg,  state_next;
    logic [1:0]                  method_reg, method_next;
    logic [asi_pkg::COST_W-1:0]  cost_reg,   cost_next;
    logic                        ovf_reg,    ovf_next;
    logic [CW-1:0]               na_reg,     na_next;
    logic [CW-1:0]               nb_reg,     nb_next;
    logic [CW-1:0]               idx_reg,    idx_next;
    logic [CW-1:0]               first_reg,  first_next;
    logic [CW-1:0]               len_reg,    len_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [IW-1:0]               pend_idx_reg,   pend_idx_next;

    logic [asi_pkg::BL_W-1:0]    bl_a;
    logic [asi_pkg::BL_W-1:0]    bl_b;
    logic [PW-1:0]               cost_a;
    logic [PW-1:0]               cost_b;
    logic [PW-1:0]               cost_m;
    logic [CW-1:0]               n_key;
    logic [CW-1:0]               n_probe;
    logic [CW-1:0]               half;
    logic                        probe_lt;
    logic                        hit;
    logic [IW-1:0]               hit_idx;
    logic                        found;
    logic [IW-1:0]               found_idx;
    logic                        blocked;
    logic [CW-1:0]               probe_addr;

    // costs from the latched counts
    assign bl_a   = asi_pkg::bit_len(na_reg);
    assign bl_b   = asi_pkg::bit_len(nb_reg);
    assign cost_a = PW'(na_reg) * PW'(bl_b);
    assign cost_b = PW'(nb_reg) * PW'(bl_a);
    assign cost_m = PW'(na_reg) + PW'(nb_reg);

    // search of A in B probes B with an A key, the other method the reverse
    assign n_key    = (method_reg == asi_pkg::METH_A_IN_B) ? na_reg : nb_reg;
    assign n_probe  = (method_reg == asi_pkg::METH_A_IN_B) ? nb_reg : na_reg;
    assign half     = {1'b0, len_reg[CW-1:1]};
    assign probe_lt = (method_reg == asi_pkg::METH_A_IN_B) ? cmp.gt : cmp.lt;
    assign hit      = (first_reg < n_probe) &&
                      ((method_reg == asi_pkg::METH_A_IN_B) ? !cmp.lt : cmp.eq);
    assign hit_idx  = (method_reg == asi_pkg::METH_A_IN_B) ? idx_reg[IW-1:0]
                                                            : first_reg[IW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        method_next     = method_reg;
        cost_next       = cost_reg;
        ovf_next        = ovf_reg;
        na_next         = na_reg;
        nb_next         = nb_reg;
        idx_next        = idx_reg;
        first_next      = first_reg;
        len_next        = len_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        emit            = 1'b0;
        emit_item.match_index = pend_idx_reg;
        emit_item.match_valid = pend_valid_reg;
        emit_item.cost        = cost_reg;
        emit_item.method      = method_reg;
        emit_item.overflowed  = ovf_reg;
        emit_item.last        = 1'b0;
        found     = 1'b0;
        found_idx = hit_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    na_next    = status.na;
                    nb_next    = status.nb;
                    ovf_next   = status.ovf;
                    state_next = S_COST;
                end
            end
            S_COST:
            begin
                idx_next        = '0;
                first_next      = '0;
                pend_valid_next = 1'b0;
                if (cost_a < cost_m && cost_a < cost_b)
                begin
                    method_next = asi_pkg::METH_A_IN_B;
                    cost_next   = asi_pkg::COST_W'(cost_a);
                    len_next    = nb_reg;
                    state_next  = (na_reg == '0) ? S_FINISH : S_SEARCH;
                end
                else if (cost_b < cost_m)
                begin
                    method_next = asi_pkg::METH_B_IN_A;
                    cost_next   = asi_pkg::COST_W'(cost_b);
                    len_next    = na_reg;
                    state_next  = (nb_reg == '0) ? S_FINISH : S_SEARCH;
                end
                else
                begin
                    method_next = asi_pkg::METH_MERGE;
                    cost_next   = asi_pkg::COST_W'(cost_m);
                    state_next  = (na_reg == '0 || nb_reg == '0) ? S_FINISH : S_MERGE;
                end
            end
            S_SEARCH:
            begin
                if (len_reg != '0)
                begin
                    if (probe_lt)
                    begin
                        first_next = first_reg + half + 1'b1;
                        len_next   = len_reg - half - 1'b1;
                    end
                    else
                    begin
                        len_next = half;
                    end
                end
                else
                begin
                    // probe already sits at the lower bound
                    found = hit;
                    if (!(found && pend_valid_reg && !out_free))
                    begin
                        idx_next   = idx_reg + 1'b1;
                        first_next = '0;
                        len_next   = n_probe;
                        if (idx_reg + 1'b1 == n_key)
                        begin
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_MERGE:
            begin
                found     = cmp.eq;
                found_idx = idx_reg[IW-1:0];
                if (!(found && pend_valid_reg && !out_free))
                begin
                    if (cmp.eq)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        first_next = first_reg + 1'b1;
                    end
                    else if (cmp.lt)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        first_next = first_reg + 1'b1;
                    end
                    if (idx_next == na_reg || first_next == nb_reg)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_item.match_index = pend_valid_reg ? pend_idx_reg : '0;
                    emit_item.last        = 1'b1;
                    pend_valid_next       = 1'b0;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // one match is held back so the final one can carry last
        blocked = found && pend_valid_reg && !out_free;
        if (found && !blocked)
        begin
            emit            = pend_valid_reg;
            pend_valid_next = 1'b1;
            pend_idx_next   = found_idx;
        end
    end

    assign probe_addr = first_next + {1'b0, len_next[CW-1:1]};

    always_comb
    begin
        if (method_next == asi_pkg::METH_B_IN_A)
        begin
            rd.a = probe_addr[IW-1:0];
            rd.b = idx_next[IW-1:0];
        end
        else if (method_next == asi_pkg::METH_A_IN_B)
        begin
            rd.a = idx_next[IW-1:0];
            rd.b = probe_addr[IW-1:0];
        end
        else
        begin
            rd.a = idx_next[IW-1:0];
            rd.b = first_next[IW-1:0];
        end
    end

    assign busy = state_reg != S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            method_reg     <= asi_pkg::METH_A_IN_B;
            cost_reg       <= '0;
            ovf_reg        <= 1'b0;
            na_reg         <= '0;
            nb_reg         <= '0;
            idx_reg        <= '0;
            first_reg      <= '0;
            len_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            method_reg     <= method_next;
            cost_reg       <= cost_next;
            ovf_reg        <= ovf_next;
            na_reg         <= na_next;
            nb_reg         <= nb_next;
            idx_reg        <= idx_next;
            first_reg      <= first_next;
            len_reg        <= len_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_start_to_cost: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg == S_COST)
        else $error("run request did not start cost selection");

    a_emit_when_running: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (state_reg == S_SEARCH || state_reg == S_MERGE || state_reg == S_FINISH))
        else $error("result emitted outside a run");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_item.last) |=> state_reg == S_IDLE)
        else $error("run did not end after final result");

    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |->
            ({1'b0, first_reg} + {1'b0, len_reg}) <= {1'b0, n_probe})
        else $error("search window beyond list length");

    a_merge_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MERGE |-> (idx_reg < na_reg && first_reg < nb_reg))
        else $error("merge position beyond list length");
`endif

endmodule

`default_nettype wire

[rtl/adaptive_sorted_intersection.sv]
// cmd_stall stays low while idle, so appends go one per cycle
// run: the counts are latched and the cost choice is made, then each key is binary
//   searched or the lists are merged, then the run closes with a last result;
//   res_stall holds the sequencer while a result waits
// cmd_stall is high for the whole run; results leave through one output register
// reset clears counts, overflow flag, sequencer and output valid; list contents undefined
`default_nettype none

module adaptive_sorted_intersection (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire asi_pkg::cmd_t cmd,
    output logic               res_valid,
    input  wire logic          res_stall,
    output asi_pkg::res_t      res
);

    logic                            cmd_accept;
    logic                            start;
    logic                            busy;
    logic                            emit;
    logic                            out_free;
    asi_pkg::res_t                   emit_item;
    asi_pkg::rd_addr_t               rd;
    asi_pkg::lst_status_t            status;
    asi_pkg::cmp_res_t               cmp;
    logic [asi_pkg::VALUE_WIDTH-1:0] a_rdata;
    logic [asi_pkg::VALUE_WIDTH-1:0] b_rdata;
    logic                            res_valid_reg;
    asi_pkg::res_t                   res_reg;

    assign cmd_stall  = busy;
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign start      = cmd_accept && cmd.operation == asi_pkg::OP_RUN;
    assign out_free   = !res_valid_reg || !res_stall;

    asi_lists u_lists (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_accept),
        .cmd     (cmd),
        .rd      (rd),
        .a_rdata (a_rdata),
        .b_rdata (b_rdata),
        .status  (status)
    );

    asi_cmp u_cmp (
        .a   (a_rdata),
        .b   (b_rdata),
        .res (cmp)
    );

    asi_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .status    (status),
        .cmp       (cmp),
        .out_free  (out_free),
        .rd        (rd),
        .busy      (busy),
        .emit      (emit),
        .emit_item (emit_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= emit_item;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[bench/asi_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// scoreboard class that predicts and checks the intersection results
package asi_scoreboard_pkg;

    class intersection_scoreboard;
        logic [31:0]   list_a [asi_pkg::MAX_LEN];
        logic [31:0]   list_b [asi_pkg::MAX_LEN];
        int unsigned   count_a;
        int unsigned   count_b;
        bit            dropped;
        asi_pkg::res_t expected_matches [$];
        int            errors;

        function new();
            count_a = 0;
            count_b = 0;
            dropped = 1'b0;
            errors  = 0;
        endfunction

        function int unsigned bit_length(int unsigned n);
            int unsigned r;
            r = 0;
            while (n != 0)
            begin
                r++;
                n = n >> 1;
            end
            return r;
        endfunction

        // plain lower-bound walk, defined even on unsorted contents
        function int unsigned search_pos(bit in_a, int unsigned n, logic [31:0] key);
            int unsigned first;
            int unsigned len;
            int unsigned half;
            logic [31:0] probe;
            first = 0;
            len   = n;
            while (len > 0)
            begin
                half  = len / 2;
                probe = in_a ? list_a[first + half] : list_b[first + half];
                if (probe < key)
                begin
                    first = first + half + 1;
                    len   = len - half - 1;
                end
                else
                begin
                    len = half;
                end
            end
            return first;
        endfunction

        function void intersect_lists();
            int unsigned   cost_a;
            int unsigned   cost_b;
            int unsigned   cost_m;
            int unsigned   cost;
            int unsigned   p;
            int unsigned   i;
            int unsigned   j;
            int unsigned   hits [$];
            logic [1:0]    method;
            asi_pkg::res_t r;
            cost_a = count_a * bit_length(count_b);
            cost_b = count_b * bit_length(count_a);
            cost_m = count_a + count_b;
            if (cost_a < cost_m && cost_a < cost_b)
            begin
                method = asi_pkg::METH_A_IN_B;
                cost   = cost_a;
                for (i = 0; i < count_a; i++)
                begin
                    p = search_pos(1'b0, count_b, list_a[i]);
                    if (p < count_b && !(list_a[i] < list_b[p]) &&
                        hits.size() < asi_pkg::MAX_LEN)
                        hits = {hits, i};
                end
            end
            else if (cost_b < cost_m)
            begin
                method = asi_pkg::METH_B_IN_A;
                cost   = cost_b;
                for (i = 0; i < count_b; i++)
                begin
                    p = search_pos(1'b1, count_a, list_b[i]);
                    if (p < count_a && list_a[p] == list_b[i] &&
                        hits.size() < asi_pkg::MAX_LEN)
                        hits = {hits, p};
                end
            end
            else
            begin
                method = asi_pkg::METH_MERGE;
                cost   = cost_m;
                i = 0;
                j = 0;
                while (i < count_a && j < count_b)
                begin
                    if (list_a[i] == list_b[j])
                    begin
                        if (hits.size() < asi_pkg::MAX_LEN)
                            hits = {hits, i};
                        i++;
                        j++;
                    end
                    else if (list_a[i] < list_b[j])
                        i++;
                    else
                        j++;
                end
            end

            r            = '0;
            r.cost       = cost[asi_pkg::COST_W-1:0];
            r.method     = method;
            r.overflowed = dropped;
            if (hits.size() == 0)
            begin
                // empty intersection still reports one closing result
                r.last = 1'b1;
                expected_matches = {expected_matches, r};
            end
            else
            begin
                foreach (hits[k])
                begin
                    r.match_index = hits[k][5:0];
                    r.match_valid = 1'b1;
                    r.last        = (k == hits.size() - 1);
                    expected_matches = {expected_matches, r};
                end
            end
            count_a = 0;
            count_b = 0;
            dropped = 1'b0;
        endfunction

        function void note(asi_pkg::cmd_t c);
            case (c.operation)
                asi_pkg::OP_APPEND_A:
                begin
                    if (count_a < asi_pkg::MAX_LEN)
                    begin
                        list_a[count_a] = c.value;
                        count_a++;
                    end
                    else
                        dropped = 1'b1;
                end
                asi_pkg::OP_APPEND_B:
                begin
                    if (count_b < asi_pkg::MAX_LEN)
                    begin
                        list_b[count_b] = c.value;
                        count_b++;
                    end
                    else
                        dropped = 1'b1;
                end
                asi_pkg::OP_RUN:
                    intersect_lists();
                default:
                    ;
            endcase
        endfunction

        function void flag(string what, asi_pkg::res_t want, asi_pkg::res_t got);
            errors++;
            if (errors <= 10)
            begin
                $display("%s: expected idx=%0d valid=%0b cost=%0d method=%0d ovf=%0b last=%0b",
                         what, want.match_index, want.match_valid, want.cost, want.method,
                         want.overflowed, want.last);
                $display("%s: got      idx=%0d valid=%0b cost=%0d method=%0d ovf=%0b last=%0b",
                         what, got.match_index, got.match_valid, got.cost, got.method,
                         got.overflowed, got.last);
            end
        endfunction

        function void check(asi_pkg::res_t got);
            asi_pkg::res_t want;
            if (expected_matches.size() == 0)
            begin
                flag("unexpected result", '0, got);
                return;
            end
            want = expected_matches.pop_front();
            if (got.match_index !== want.match_index || got.match_valid !== want.match_valid ||
                got.cost !== want.cost || got.method !== want.method ||
                got.overflowed !== want.overflowed || got.last !== want.last)
                flag("mismatch", want, got);
        endfunction
    endclass

endpackage

[bench/tb.sv]
`timescale 1ns / 1ps
// testbench top for the adaptive sorted intersection block
module tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cmd_valid = 1'b0;
    logic          cmd_stall;
    asi_pkg::cmd_t cmd       = '0;
    logic          res_valid;
    logic          res_stall = 1'b0;
    asi_pkg::res_t res;

    asi_scoreboard_pkg::intersection_scoreboard sb = new();
    bit quiet      = 1'b0;
    int sent_items = 0;

    adaptive_sorted_intersection dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check(res);
        res_stall <= !quiet && ($urandom_range(0, 99) < 32);
    end

    task automatic send(input asi_pkg::cmd_t c);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 25)
        begin
            gap = $urandom_range(1, 3);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note(c);
        if (c.operation != OP_UNUSED)
            sent_items++;
    endtask

    task automatic append(input logic [1:0] op, input logic [31:0] v);
        asi_pkg::cmd_t c;
        c.operation = op;
        c.value     = v;
        send(c);
    endtask

    task automatic load_and_run(input int na, input int nb, input bit noisy, input int surplus);
        logic [31:0] a_q [$];
        logic [31:0] b_q [$];
        logic [63:0] v;
        int          pick;
        int          ia;
        int          ib;
        bit          narrow;
        logic [1:0]  extra_op;
        if (noisy)
        begin
            // unsorted or repeated contents
            narrow = $urandom_range(0, 1);
            while (a_q.size() < na)
                a_q = {a_q, narrow ? $urandom_range(0, 7) : $urandom};
            while (b_q.size() < nb)
                b_q = {b_q, narrow ? $urandom_range(0, 7) : $urandom};
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       v = {32'h0, $urandom};
                1:       v = 64'hFFFF_FFFF - 64'($urandom_range(0, 400));
                default: v = 64'($urandom_range(0, 200));
            endcase
            // walk one rising sequence and deal values to A, B or both
            while (a_q.size() < na || b_q.size() < nb)
            begin
                v = v + 64'($urandom_range(1, 3));
                if (v > 64'hFFFF_FFFF)
                    break;
                pick = $urandom_range(0, 2);
                if (pick != 1 && a_q.size() < na)
                    a_q = {a_q, v[31:0]};
                if (pick != 0 && b_q.size() < nb)
                    b_q = {b_q, v[31:0]};
            end
        end
        ia = 0;
        ib = 0;
        while (ia < a_q.size() || ib < b_q.size())
        begin
            if (ib >= b_q.size() || (ia < a_q.size() && $urandom_range(0, 1) == 1))
            begin
                append(asi_pkg::OP_APPEND_A, a_q[ia]);
                ia++;
            end
            else
            begin
                append(asi_pkg::OP_APPEND_B, b_q[ib]);
                ib++;
            end
            if (noisy && $urandom_range(0, 9) == 0)
                append(OP_UNUSED, $urandom);
        end
        extra_op = (a_q.size() >= asi_pkg::MAX_LEN) ? asi_pkg::OP_APPEND_A
                                                    : asi_pkg::OP_APPEND_B;
        repeat (surplus)
            append(extra_op, $urandom);
        append(asi_pkg::OP_RUN, $urandom);
    endtask

    initial
    begin
        int na;
        int nb;
        int kind;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty lists: every cost is zero, so the merge is chosen
        append(asi_pkg::OP_RUN, 32'hFFFF_FFFF);
        append(OP_UNUSED, 32'hA5A5_5A5A);

        // value extremes, searched B in A
        append(asi_pkg::OP_APPEND_A, 32'h0000_0000);
        append(asi_pkg::OP_APPEND_A, 32'h0000_0005);
        append(asi_pkg::OP_APPEND_A, 32'hFFFF_FFFF);
        append(asi_pkg::OP_APPEND_B, 32'h0000_0005);
        append(asi_pkg::OP_APPEND_B, 32'hFFFF_FFFF);
        append(asi_pkg::OP_RUN, 32'h0);

        // one A value searched in eight B values
        append(asi_pkg::OP_APPEND_A, 32'h8000_0000);
        for (int k = 24; k < 32; k++)
            append(asi_pkg::OP_APPEND_B, 32'h1 << k);
        append(asi_pkg::OP_RUN, 32'h0);

        // unsorted list with a repeat
        append(asi_pkg::OP_APPEND_A, 32'd7);
        append(asi_pkg::OP_APPEND_A, 32'd3);
        append(asi_pkg::OP_APPEND_A, 32'd3);
        append(asi_pkg::OP_APPEND_B, 32'd3);
        append(asi_pkg::OP_APPEND_B, 32'd7);
        append(asi_pkg::OP_RUN, 32'h0);

        while (sent_items < 255)
        begin
            quiet <= (sent_items >= 120 && sent_items < 190);
            kind = $urandom_range(0, 19);
            if (kind == 0)
            begin
                // full list, sometimes pushed past capacity
                if ($urandom_range(0, 1) == 1)
                begin
                    na = asi_pkg::MAX_LEN;
                    nb = $urandom_range(0, asi_pkg::MAX_LEN);
                end
                else
                begin
                    nb = asi_pkg::MAX_LEN;
                    na = $urandom_range(0, asi_pkg::MAX_LEN);
                end
                load_and_run(na, nb, 1'b0, $urandom_range(0, 3));
            end
            else if (kind < 4)
                load_and_run($urandom_range(0, 10), $urandom_range(0, 10), 1'b1, 0);
            else if (kind < 8)
            begin
                // lopsided sizes favor the binary searches
                na = $urandom_range(0, 3);
                nb = $urandom_range(6, 24);
                if ($urandom_range(0, 1) == 1)
                    load_and_run(nb, na, 1'b0, 0);
                else
                    load_and_run(na, nb, 1'b0, 0);
            end
            else
                load_and_run($urandom_range(0, 12), $urandom_range(0, 12), 1'b0, 0);
        end
        quiet     <= 1'b0;
        cmd_valid <= 1'b0;

        while (sb.expected_matches.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("adaptive_sorted_intersection test passed");
        else
            $display("adaptive_sorted_intersection test failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("adaptive_sorted_intersection test failed");
        $finish;
    end

endmodule
